// ===== rtl/core/tgs_pkg.sv =====
// types and constants shared by the trilinear grid sampler and its checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tgs_pkg;

  localparam int POS_BITS     = 16;
  localparam int SIZE_BITS    = 5;
  localparam int ADDR_BITS    = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int STEP_BITS    = 4;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    MAC_NONE,
    MAC_X_FIRST,
    MAC_X_ACC,
    MAC_Y_FIRST,
    MAC_Y_ACC,
    MAC_Z_FIRST,
    MAC_Z_ACC
  } mac_op_t;

  typedef struct packed {
    logic       rd_en;
    logic [2:0] corner;
    mac_op_t    op;
    logic       last;
  } seq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/trilinear_grid_sampler_top.sv =====
// trilinear grid sampler: grid memory, sequencer and shared multiply-accumulate unit
// depends on tgs_pkg
`timescale 1ns / 1ps
`default_nettype none

// A write beat (in_cmd = 0) stores one grid cell in the cycle it is taken, unless its address
// is past the grid depth, and leaves busy low. A sample beat (in_cmd = 1) holds busy high while
// the sequencer runs; the result is on out_sample_value for the one cycle out_valid is high,
// the cycle right after busy drops. The receiver cannot stall: out_valid is a single-cycle
// strobe. The busy time comes from the single multiply-accumulate unit, which forms 14
// products per sample (eight corner-by-x-weight, four by y-weight, two by z-weight), fed by
// the one read port of the grid memory. Grid cells hold no reset value and must be written
// before they are read.
module trilinear_grid_sampler_top #(
  parameter int MAX_X      = 16,
  parameter int MAX_Y      = 16,
  parameter int MAX_Z      = 16,
  parameter int VALUE_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic [tgs_pkg::ADDR_BITS-1:0]     in_cell_address,
  input  wire logic signed [VALUE_BITS-1:0]      in_cell_value,
  input  wire logic signed [tgs_pkg::POS_BITS-1:0] in_pos_x,
  input  wire logic signed [tgs_pkg::POS_BITS-1:0] in_pos_y,
  input  wire logic signed [tgs_pkg::POS_BITS-1:0] in_pos_z,
  output logic                                   out_valid,
  output logic signed [VALUE_BITS-1:0]           out_sample_value,
  input  wire logic                              cfg_we,
  input  wire logic [tgs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [tgs_pkg::SIZE_BITS-1:0]     cfg_data
);

  import tgs_pkg::*;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int DW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_X);
  localparam int YW    = $clog2(MAX_Y);
  localparam int ZW    = $clog2(MAX_Z);
  localparam int WW    = FRAC_BITS + 1;
  localparam int AXW   = VALUE_BITS + FRAC_BITS + 1;
  localparam int AYW   = VALUE_BITS + 2 * FRAC_BITS + 1;
  localparam int AZW   = VALUE_BITS + 3 * FRAC_BITS + 1;
  localparam int PW    = AYW + WW;
  localparam logic [WW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [31:0] sat_size(input logic [SIZE_BITS-1:0] v,
                                            input logic [31:0] maxv);
    logic [31:0] r;
    begin
      if (v == '0) r = 32'd1;
      else if (32'(v) > maxv) r = maxv;
      else r = 32'(v);
      return r;
    end
  endfunction

  function automatic logic [31:0] clamp_pos(input logic [POS_BITS-1:0] raw,
                                             input logic [31:0] n);
    logic [31:0] hi;
    logic [31:0] p;
    begin
      hi = (n - 32'd1) << FRAC_BITS;
      p  = 32'(raw);
      if (raw[POS_BITS-1]) p = '0;
      else if (p > hi) p = hi;
      return p;
    end
  endfunction

  // configuration
  logic [SIZE_BITS-1:0] size_x_r, size_y_r, size_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x_r <= cfg_data;
        CFG_SIZE_Y: size_y_r <= cfg_data;
        CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  state_t   state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  seq_ctl_t ctl;
  logic     take, take_sample, take_write;

  assign take        = start && !busy;
  assign take_sample = take && (in_cmd == CMD_SAMPLE);
  assign take_write  = take && (in_cmd == CMD_WRITE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (take_sample) state_nxt = ST_RUN;
      ST_RUN:  if (ctl.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // read/mac schedule: reads run one step ahead of the x products
  always_comb begin
    ctl = '0;
    busy = (state_r == ST_RUN);
    if (state_r == ST_RUN) begin
      unique case (step_r)
        4'd0:  ctl = '{rd_en: 1'b1, corner: 3'd0, op: MAC_NONE,    last: 1'b0};
        4'd1:  ctl = '{rd_en: 1'b1, corner: 3'd1, op: MAC_X_FIRST, last: 1'b0};
        4'd2:  ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_X_ACC,   last: 1'b0};
        4'd3:  ctl = '{rd_en: 1'b1, corner: 3'd2, op: MAC_Y_FIRST, last: 1'b0};
        4'd4:  ctl = '{rd_en: 1'b1, corner: 3'd3, op: MAC_X_FIRST, last: 1'b0};
        4'd5:  ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_X_ACC,   last: 1'b0};
        4'd6:  ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_Y_ACC,   last: 1'b0};
        4'd7:  ctl = '{rd_en: 1'b1, corner: 3'd4, op: MAC_Z_FIRST, last: 1'b0};
        4'd8:  ctl = '{rd_en: 1'b1, corner: 3'd5, op: MAC_X_FIRST, last: 1'b0};
        4'd9:  ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_X_ACC,   last: 1'b0};
        4'd10: ctl = '{rd_en: 1'b1, corner: 3'd6, op: MAC_Y_FIRST, last: 1'b0};
        4'd11: ctl = '{rd_en: 1'b1, corner: 3'd7, op: MAC_X_FIRST, last: 1'b0};
        4'd12: ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_X_ACC,   last: 1'b0};
        4'd13: ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_Y_ACC,   last: 1'b0};
        4'd14: ctl = '{rd_en: 1'b0, corner: 3'd0, op: MAC_Z_ACC,   last: 1'b1};
        default: ctl = '0;
      endcase
    end
  end

  assign step_nxt = (ctl.last || state_r == ST_IDLE) ? '0 : step_r + 1'b1;

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= ctl.last;
    end
  end

  // position split at sample start
  logic [31:0] px, py, pz;

  assign px = clamp_pos(in_pos_x, sat_size(size_x_r, 32'(MAX_X)));
  assign py = clamp_pos(in_pos_y, sat_size(size_y_r, 32'(MAX_Y)));
  assign pz = clamp_pos(in_pos_z, sat_size(size_z_r, 32'(MAX_Z)));

  logic [XW-1:0] base_x_r;
  logic [YW-1:0] base_y_r;
  logic [ZW-1:0] base_z_r;
  logic [FRAC_BITS-1:0] frac_x_r, frac_y_r, frac_z_r;

  always_ff @(posedge clk) begin
    if (take_sample) begin
      base_x_r <= XW'(px >> FRAC_BITS);
      base_y_r <= YW'(py >> FRAC_BITS);
      base_z_r <= ZW'(pz >> FRAC_BITS);
      frac_x_r <= px[FRAC_BITS-1:0];
      frac_y_r <= py[FRAC_BITS-1:0];
      frac_z_r <= pz[FRAC_BITS-1:0];
    end
  end

  // grid memory
  logic signed [VALUE_BITS-1:0] grid_mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_data_r;
  logic                         rd_skip_r;
  logic [DW-1:0]                wr_idx, rd_idx;
  logic                         wr_en, rd_skip;
  logic [31:0]                  cx, cy, cz, caddr;

  assign wr_en  = take_write && (32'(in_cell_address) < 32'(DEPTH));
  assign wr_idx = DW'(in_cell_address);

  assign cx    = 32'(base_x_r) + 32'(ctl.corner[0]);
  assign cy    = 32'(base_y_r) + 32'(ctl.corner[1]);
  assign cz    = 32'(base_z_r) + 32'(ctl.corner[2]);
  assign caddr = cx + 32'(MAX_X) * (cy + 32'(MAX_Y) * cz);
  assign rd_idx = DW'(caddr);

  // a far corner with zero fraction has zero weight and may lie off the grid
  assign rd_skip = (ctl.corner[0] && frac_x_r == '0) ||
                   (ctl.corner[1] && frac_y_r == '0) ||
                   (ctl.corner[2] && frac_z_r == '0);

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_idx] <= in_cell_value;
    if (ctl.rd_en) begin
      rd_skip_r <= rd_skip;
      if (!rd_skip) rd_data_r <= grid_mem[rd_idx];
    end
  end

  // shared multiply-accumulate
  logic signed [VALUE_BITS-1:0] cell_val;
  logic signed [AXW-1:0] accx_r, accx_nxt;
  logic signed [AYW-1:0] accy_r, accy_nxt;
  logic signed [AZW-1:0] accz_r, accz_nxt;
  logic signed [AYW-1:0] a_op;
  logic [WW-1:0]         b_op;
  logic signed [PW-1:0]  a_ext, b_ext, prod;

  assign cell_val = rd_skip_r ? '0 : rd_data_r;

  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (ctl.op)
      MAC_X_FIRST: begin a_op = AYW'(cell_val); b_op = ONE_Q - WW'(frac_x_r); end
      MAC_X_ACC:   begin a_op = AYW'(cell_val); b_op = WW'(frac_x_r); end
      MAC_Y_FIRST: begin a_op = AYW'(accx_r);   b_op = ONE_Q - WW'(frac_y_r); end
      MAC_Y_ACC:   begin a_op = AYW'(accx_r);   b_op = WW'(frac_y_r); end
      MAC_Z_FIRST: begin a_op = accy_r;         b_op = ONE_Q - WW'(frac_z_r); end
      MAC_Z_ACC:   begin a_op = accy_r;         b_op = WW'(frac_z_r); end
      default: ;
    endcase
  end

  assign a_ext = PW'(a_op);
  assign b_ext = PW'(b_op);
  assign prod  = a_ext * b_ext;

  always_comb begin
    accx_nxt = accx_r;
    accy_nxt = accy_r;
    accz_nxt = accz_r;
    unique case (ctl.op)
      MAC_X_FIRST: accx_nxt = AXW'(prod);
      MAC_X_ACC:   accx_nxt = accx_r + AXW'(prod);
      MAC_Y_FIRST: accy_nxt = AYW'(prod);
      MAC_Y_ACC:   accy_nxt = accy_r + AYW'(prod);
      MAC_Z_FIRST: accz_nxt = AZW'(prod);
      MAC_Z_ACC:   accz_nxt = accz_r + AZW'(prod);
      default: ;
    endcase
  end

  logic signed [VALUE_BITS-1:0] out_sample_value_r;

  always_ff @(posedge clk) begin
    accx_r <= accx_nxt;
    accy_r <= accy_nxt;
    accz_r <= accz_nxt;
    // floor shift by the three weight scales
    if (ctl.last) out_sample_value_r <= accz_nxt[3*FRAC_BITS +: VALUE_BITS];
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_value_r;

endmodule

`default_nettype wire

// ===== rtl/core/tgs_checker.sv =====
// port-level checker for the trilinear grid sampler, bound to the top level
// depends on tgs_pkg and trilinear_grid_sampler_top
`timescale 1ns / 1ps
`default_nettype none

module tgs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_cmd,
  input wire logic out_valid
);

  import tgs_pkg::*;

  // a result only shows once the sample work is done
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // write beats leave busy low and give no result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_WRITE) |=> (!busy && !out_valid))
    else $error("write beat caused busy or a result");

  // a sample beat starts the sequencer
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_SAMPLE) |=> busy)
    else $error("sample beat did not raise busy");

  // end of work always delivers exactly one result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind trilinear_grid_sampler_top tgs_checker u_tgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);

`default_nettype wire
